>>> design/hbs_pkg.sv
package hbs_pkg;

   localparam int MAX_BINS    = 64;
   localparam int SAMPLE_BITS = 32;
   localparam int COUNT_BITS  = 32;
   localparam int SLOTS       = MAX_BINS + 2;
   localparam int OVER_SLOT   = MAX_BINS + 1;
   localparam int SLOT_BITS   = $clog2(SLOTS);
   localparam int WIDTH_BITS  = 16;
   localparam int NBINS_BITS  = 7;
   localparam int STEP_BITS   = $clog2(SAMPLE_BITS);
   localparam int ADDR_BITS   = 4;
   localparam int DATA_BITS   = 32;

   // register indexes on the APB port (word address)
   localparam logic [1:0] REG_RANGE_LOW   = 2'd0;
   localparam logic [1:0] REG_BIN_WIDTH   = 2'd1;
   localparam logic [1:0] REG_BINS_IN_USE = 2'd2;

   localparam logic [WIDTH_BITS-1:0] BIN_WIDTH_RESET   = WIDTH_BITS'(10);
   localparam logic [NBINS_BITS-1:0] BINS_IN_USE_RESET = NBINS_BITS'(20);

   typedef enum logic [1:0] {
      ACT_RECORD = 2'd0,
      ACT_READ   = 2'd1,
      ACT_TOTALS = 2'd2,
      ACT_CLEAR  = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_LOOKUP,
      ST_UPDATE,
      ST_TOTALS
   } state_type;

   typedef struct packed {
      logic [COUNT_BITS-1:0]  tally;
      logic                   wrapped;
      logic [SAMPLE_BITS-1:0] least;
      logic [SAMPLE_BITS-1:0] greatest;
   } entry_type;

   localparam entry_type ENTRY_RESET = '{
      tally:    '0,
      wrapped:  1'b0,
      least:    '1,
      greatest: '0
   };

   typedef struct packed {
      action_type             action;
      logic [SAMPLE_BITS-1:0] sample;
      logic [6:0]             bin_select;
   } req_type;

   typedef struct packed {
      logic [6:0]             bin_used;
      logic [COUNT_BITS-1:0]  tally;
      logic                   tally_overflowed;
      logic [SAMPLE_BITS-1:0] low_value;
      logic [SAMPLE_BITS-1:0] high_value;
      logic                   nonempty;
      logic [SAMPLE_BITS-1:0] running_sum;
      logic                   sum_wrap;
   } rsp_type;

endpackage

>>> design/hbs_req_if.sv
interface hbs_req_if import hbs_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

>>> design/hbs_rsp_if.sv
interface hbs_rsp_if import hbs_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

>>> design/hbs_ram.sv
module hbs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

>>> design/histogram_bin_statistics.sv
// Histogram of unsigned samples with an underflow bin, up to 64 regular bins and an
// overflow bin; each bin holds count, wrap flag, least and greatest in one RAM, while
// totals and the running sum live in flops. One item is handled at a time. A record
// is accepted, runs 32 steps of the radix-2 bin-index divider, then a RAM read and an
// update; a sample below the range skips the divider, and so does a bin read, going
// from accept to RAM read and update; totals and clear go to the totals state. The
// update or totals cycle holds while the previous result still waits on the output.
// Clear is immediate: per-bin valid flops make uncleared entries read as empty.
// Write registers only while the block is idle.
module histogram_bin_statistics import hbs_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   hbs_req_if.sink              req_chan,
   hbs_rsp_if.source            rsp_chan,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [ADDR_BITS-1:0] paddr,
   input  logic [DATA_BITS-1:0] pwdata,
   output logic [DATA_BITS-1:0] prdata,
   output logic                 pready
);

   // configuration registers
   logic [SAMPLE_BITS-1:0] range_low_ff;
   logic [WIDTH_BITS-1:0]  bin_width_ff;
   logic [NBINS_BITS-1:0]  bins_in_use_ff;
   logic                   cfg_write;

   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         range_low_ff   <= '0;
         bin_width_ff   <= BIN_WIDTH_RESET;
         bins_in_use_ff <= BINS_IN_USE_RESET;
      end else if (cfg_write) begin
         case (paddr[3:2])
            REG_RANGE_LOW:   range_low_ff   <= pwdata[SAMPLE_BITS-1:0];
            REG_BIN_WIDTH:   bin_width_ff   <= pwdata[WIDTH_BITS-1:0];
            REG_BINS_IN_USE: bins_in_use_ff <= pwdata[NBINS_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         REG_RANGE_LOW:   prdata = DATA_BITS'(range_low_ff);
         REG_BIN_WIDTH:   prdata = DATA_BITS'(bin_width_ff);
         REG_BINS_IN_USE: prdata = DATA_BITS'(bins_in_use_ff);
         default:         prdata = '0;
      endcase
   end

   // effective bin count and width
   logic [NBINS_BITS-1:0] n_bins;
   logic [WIDTH_BITS-1:0] eff_width;

   always_comb begin
      if (bins_in_use_ff == '0) begin
         n_bins = NBINS_BITS'(1);
      end else if (bins_in_use_ff > NBINS_BITS'(MAX_BINS)) begin
         n_bins = NBINS_BITS'(MAX_BINS);
      end else begin
         n_bins = bins_in_use_ff;
      end
      eff_width = (bin_width_ff == '0) ? WIDTH_BITS'(1) : bin_width_ff;
   end

   // state and item registers
   state_type              state_ff, state_in;
   action_type             act_ff;
   logic [SAMPLE_BITS-1:0] sample_ff;
   logic [6:0]             sel_ff;
   logic                   below_ff;
   logic [WIDTH_BITS-1:0]  rem_ff, rem_in;
   logic [SAMPLE_BITS-1:0] quo_ff, quo_in;
   logic [STEP_BITS-1:0]   step_ff;
   logic [SLOT_BITS-1:0]   slot_ff, slot_in;
   logic [6:0]             used_ff, used_in;
   logic                   rd_valid_ff;

   // totals
   logic [COUNT_BITS-1:0]  total_tally_ff;
   logic                   total_wrapped_ff;
   logic [SAMPLE_BITS-1:0] sum_ff;
   logic                   sum_wrapped_ff;
   logic [SAMPLE_BITS-1:0] least_ff;
   logic [SAMPLE_BITS-1:0] greatest_ff;
   logic [SLOTS-1:0]       valid_ff;

   // output register
   logic    rsp_valid_ff;
   rsp_type rsp_ff, rsp_in;
   logic    rsp_load;
   logic    out_free;

   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.payload = rsp_ff;

   logic req_take;
   assign req_take = req_chan.valid && req_chan.ready;

   // divider step: shift in one dividend bit, subtract when it fits
   logic [WIDTH_BITS:0] trial;
   logic                fits;
   assign trial = {rem_ff, quo_ff[SAMPLE_BITS-1]};
   assign fits  = trial >= {1'b0, eff_width};

   // memory
   logic      ram_we, ram_re;
   entry_type ram_rdata, cur_entry, new_entry;

   hbs_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (SLOTS)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (slot_ff),
      .wdata (new_entry),
      .re    (ram_re),
      .raddr (slot_in),
      .rdata (ram_rdata)
   );

   assign cur_entry = rd_valid_ff ? ram_rdata : ENTRY_RESET;

   // slot and bin number for record and read
   logic [6:0] sel_sat;
   logic [6:0] n_plus;

   always_comb begin
      n_plus  = n_bins + 7'd1;
      sel_sat = (sel_ff > n_plus) ? n_plus : sel_ff;
      if (act_ff == ACT_RECORD) begin
         if (below_ff) begin
            slot_in = '0;
            used_in = '0;
         end else if (quo_ff >= SAMPLE_BITS'(n_bins)) begin
            slot_in = SLOT_BITS'(OVER_SLOT);
            used_in = n_plus;
         end else begin
            slot_in = SLOT_BITS'(quo_ff) + SLOT_BITS'(1);
            used_in = 7'(quo_ff) + 7'd1;
         end
      end else begin
         used_in = sel_sat;
         slot_in = (sel_sat == n_plus) ? SLOT_BITS'(OVER_SLOT) : SLOT_BITS'(sel_sat);
      end
   end

   // bin update for a record
   logic [COUNT_BITS-1:0]  bin_inc;
   logic [COUNT_BITS-1:0]  tot_inc;
   logic [SAMPLE_BITS:0]   sum_add;
   logic [SAMPLE_BITS-1:0] new_least, new_greatest;

   always_comb begin
      bin_inc = cur_entry.tally + COUNT_BITS'(1);
      new_entry = cur_entry;
      if (!cur_entry.wrapped) begin
         new_entry.tally   = bin_inc;
         new_entry.wrapped = (bin_inc == '0);
      end
      if (sample_ff < cur_entry.least) begin
         new_entry.least = sample_ff;
      end
      if (sample_ff > cur_entry.greatest) begin
         new_entry.greatest = sample_ff;
      end
      tot_inc      = total_tally_ff + COUNT_BITS'(1);
      sum_add      = {1'b0, sum_ff} + {1'b0, sample_ff};
      new_least    = (sample_ff < least_ff) ? sample_ff : least_ff;
      new_greatest = (sample_ff > greatest_ff) ? sample_ff : greatest_ff;
   end

   // next state and outputs
   always_comb begin
      state_in = state_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      ram_re   = 1'b0;
      ram_we   = 1'b0;
      rsp_load = 1'b0;
      rsp_in   = rsp_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               rem_in = '0;
               quo_in = req_chan.payload.sample - range_low_ff;
               case (req_chan.payload.action)
                  ACT_RECORD: begin
                     state_in = (req_chan.payload.sample < range_low_ff) ?
                                ST_LOOKUP : ST_DIVIDE;
                  end
                  ACT_READ: state_in = ST_LOOKUP;
                  default:  state_in = ST_TOTALS;
               endcase
            end
         end
         ST_DIVIDE: begin
            rem_in = fits ? WIDTH_BITS'(trial - {1'b0, eff_width}) : trial[WIDTH_BITS-1:0];
            quo_in = {quo_ff[SAMPLE_BITS-2:0], fits};
            if (step_ff == STEP_BITS'(SAMPLE_BITS - 1)) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            ram_re   = 1'b1;
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (out_free) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
               rsp_in.bin_used = used_ff;
               if (act_ff == ACT_RECORD) begin
                  ram_we = 1'b1;
                  rsp_in.tally            = new_entry.tally;
                  rsp_in.tally_overflowed = new_entry.wrapped;
                  rsp_in.low_value        = new_entry.least;
                  rsp_in.high_value       = new_entry.greatest;
                  rsp_in.nonempty         = 1'b1;
                  rsp_in.running_sum      = sum_wrapped_ff ? sum_ff : sum_add[SAMPLE_BITS-1:0];
                  rsp_in.sum_wrap         = sum_wrapped_ff || sum_add[SAMPLE_BITS];
               end else begin
                  rsp_in.tally            = cur_entry.tally;
                  rsp_in.tally_overflowed = cur_entry.wrapped;
                  rsp_in.low_value        = cur_entry.least;
                  rsp_in.high_value       = cur_entry.greatest;
                  rsp_in.nonempty         = (cur_entry.tally != '0) || cur_entry.wrapped;
                  rsp_in.running_sum      = sum_ff;
                  rsp_in.sum_wrap         = sum_wrapped_ff;
               end
            end
         end
         ST_TOTALS: begin
            if (out_free) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
               rsp_in.bin_used = '0;
               if (act_ff == ACT_CLEAR) begin
                  rsp_in.tally            = '0;
                  rsp_in.tally_overflowed = 1'b0;
                  rsp_in.low_value        = '1;
                  rsp_in.high_value       = '0;
                  rsp_in.nonempty         = 1'b0;
                  rsp_in.running_sum      = '0;
                  rsp_in.sum_wrap         = 1'b0;
               end else begin
                  rsp_in.tally            = total_wrapped_ff ? '0 : total_tally_ff;
                  rsp_in.tally_overflowed = total_wrapped_ff;
                  rsp_in.low_value        = least_ff;
                  rsp_in.high_value       = greatest_ff;
                  rsp_in.nonempty         = (total_tally_ff != '0) || total_wrapped_ff;
                  rsp_in.running_sum      = sum_ff;
                  rsp_in.sum_wrap         = sum_wrapped_ff;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   logic clear_now;
   assign clear_now = (state_ff == ST_TOTALS) && out_free && (act_ff == ACT_CLEAR);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         step_ff          <= '0;
         rsp_valid_ff     <= 1'b0;
         valid_ff         <= '0;
         total_tally_ff   <= '0;
         total_wrapped_ff <= 1'b0;
         sum_ff           <= '0;
         sum_wrapped_ff   <= 1'b0;
         least_ff         <= '1;
         greatest_ff      <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= (state_ff == ST_DIVIDE) ? step_ff + STEP_BITS'(1) : '0;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (clear_now) begin
            valid_ff         <= '0;
            total_tally_ff   <= '0;
            total_wrapped_ff <= 1'b0;
            sum_ff           <= '0;
            sum_wrapped_ff   <= 1'b0;
            least_ff         <= '1;
            greatest_ff      <= '0;
         end else if (ram_we) begin
            valid_ff[slot_ff] <= 1'b1;
            total_tally_ff    <= tot_inc;
            if (tot_inc == '0) begin
               total_wrapped_ff <= 1'b1;
            end
            if (!sum_wrapped_ff) begin
               sum_ff         <= sum_add[SAMPLE_BITS-1:0];
               sum_wrapped_ff <= sum_add[SAMPLE_BITS];
            end
            least_ff    <= new_least;
            greatest_ff <= new_greatest;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      rsp_ff <= rsp_in;
      if (req_take) begin
         act_ff    <= req_chan.payload.action;
         sample_ff <= req_chan.payload.sample;
         sel_ff    <= req_chan.payload.bin_select;
         below_ff  <= req_chan.payload.sample < range_low_ff;
      end
      if (state_ff == ST_LOOKUP) begin
         slot_ff     <= slot_in;
         used_ff     <= used_in;
         rd_valid_ff <= valid_ff[slot_in];
      end
   end

   // checks
   a_we_in_update: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == ST_UPDATE) && (act_ff == ACT_RECORD))
      else $error("bin write outside update of a record");

   a_sum_sticky: assert property (@(posedge clock) disable iff (reset)
      sum_wrapped_ff && !clear_now |=> sum_wrapped_ff)
      else $error("sum wrap flag dropped without clear");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> out_free)
      else $error("result register overwritten while held");

   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPDATE) |-> (slot_ff <= SLOT_BITS'(OVER_SLOT)))
      else $error("bin slot out of range");

endmodule

>>> tb/sv/hbs_checker.sv
`timescale 1ns / 100ps

module hbs_checker import hbs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   hbs_req_if.sink     req_mon,
   hbs_rsp_if.sink     rsp_mon,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic        pready,
   input  logic [ADDR_BITS-1:0] paddr,
   input  logic [DATA_BITS-1:0] pwdata,
   output int          fail_count,
   output int          pending_count
);

   // shadow registers
   logic [31:0] range_low;
   logic [15:0] bin_width;
   logic [6:0]  bins_in_use;

   // shadow store
   logic [31:0] bin_tally    [SLOTS];
   logic        bin_wrapped  [SLOTS];
   logic [31:0] bin_least    [SLOTS];
   logic [31:0] bin_greatest [SLOTS];
   logic [31:0] total_tally, sum_value, overall_least, overall_greatest;
   logic        total_wrapped, sum_wrapped;

   rsp_type expected_rsps[$];

   assign pending_count = expected_rsps.size();

   function automatic void clear_store();
      for (int i = 0; i < SLOTS; i++) begin
         bin_tally[i] = '0;
         bin_wrapped[i] = 1'b0;
         bin_least[i] = '1;
         bin_greatest[i] = '0;
      end
      total_tally = '0;
      total_wrapped = 1'b0;
      sum_value = '0;
      sum_wrapped = 1'b0;
      overall_least = '1;
      overall_greatest = '0;
   endfunction

   function automatic rsp_type slot_rsp(logic [6:0] used, int slot);
      rsp_type r;
      r.bin_used = used;
      r.tally = bin_tally[slot];
      r.tally_overflowed = bin_wrapped[slot];
      r.low_value = bin_least[slot];
      r.high_value = bin_greatest[slot];
      r.nonempty = (bin_tally[slot] != 0) || bin_wrapped[slot];
      r.running_sum = sum_value;
      r.sum_wrap = sum_wrapped;
      return r;
   endfunction

   function automatic rsp_type totals_rsp();
      rsp_type r;
      r.bin_used = '0;
      r.tally = total_wrapped ? '0 : total_tally;
      r.tally_overflowed = total_wrapped;
      r.low_value = overall_least;
      r.high_value = overall_greatest;
      r.nonempty = (total_tally != 0) || total_wrapped;
      r.running_sum = sum_value;
      r.sum_wrap = sum_wrapped;
      return r;
   endfunction

   // compute the response for one request and update the shadow store
   function automatic rsp_type histogram_update(req_type rq);
      int unsigned n, w, slot;
      logic [31:0] q, old_sum;
      logic [6:0]  used, sel;
      n = (bins_in_use == 0) ? 1 : (bins_in_use > MAX_BINS) ? MAX_BINS : bins_in_use;
      w = (bin_width == 0) ? 1 : bin_width;
      case (rq.action)
         ACT_RECORD: begin
            if (rq.sample < range_low) begin
               used = '0;
               slot = 0;
            end else begin
               q = (rq.sample - range_low) / w;
               if (q >= n) begin
                  used = 7'(n + 1);
                  slot = OVER_SLOT;
               end else begin
                  used = 7'(q + 1);
                  slot = q + 1;
               end
            end
            if (!bin_wrapped[slot]) begin
               bin_tally[slot] = bin_tally[slot] + 1;
               if (bin_tally[slot] == 0) bin_wrapped[slot] = 1'b1;
            end
            if (rq.sample < bin_least[slot]) bin_least[slot] = rq.sample;
            if (rq.sample > bin_greatest[slot]) bin_greatest[slot] = rq.sample;
            total_tally = total_tally + 1;
            if (total_tally == 0) total_wrapped = 1'b1;
            if (rq.sample < overall_least) overall_least = rq.sample;
            if (rq.sample > overall_greatest) overall_greatest = rq.sample;
            if (!sum_wrapped) begin
               old_sum = sum_value;
               sum_value = sum_value + rq.sample;
               if (sum_value < old_sum) sum_wrapped = 1'b1;
            end
            return slot_rsp(used, slot);
         end
         ACT_READ: begin
            sel = rq.bin_select;
            if (sel > n + 1) sel = 7'(n + 1);
            if (sel == 0) return slot_rsp(7'd0, 0);
            else if (sel == n + 1) return slot_rsp(sel, OVER_SLOT);
            else return slot_rsp(sel, int'(sel));
         end
         ACT_TOTALS: return totals_rsp();
         default: begin
            clear_store();
            return totals_rsp();
         end
      endcase
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         range_low <= '0;
         bin_width <= BIN_WIDTH_RESET;
         bins_in_use <= BINS_IN_USE_RESET;
         clear_store();
         expected_rsps.delete();
         fail_count <= 0;
      end else begin
         // track register writes
         if (psel && penable && pwrite && pready) begin
            case (paddr[3:2])
               REG_RANGE_LOW:   range_low <= pwdata;
               REG_BIN_WIDTH:   bin_width <= pwdata[15:0];
               REG_BINS_IN_USE: bins_in_use <= pwdata[6:0];
               default: ;
            endcase
         end
         // predict on each request transfer
         if (req_mon.valid && req_mon.ready)
            expected_rsps.push_back(histogram_update(req_mon.payload));
         // compare each response transfer
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_rsps.size() == 0) begin
               $display("%0t: unexpected response %p", $time, rsp_mon.payload);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_rsps.pop_front();
               if (want !== rsp_mon.payload) begin
                  $display("%0t: mismatch expected %p actual %p", $time, want,
                           rsp_mon.payload);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

>>> tb/sv/histogram_bin_statistics_tb.sv
`timescale 1ns / 100ps

module histogram_bin_statistics_tb;
   import hbs_pkg::*;

   localparam int CYCLE_LIMIT = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [ADDR_BITS-1:0] paddr = '0;
   logic [DATA_BITS-1:0] pwdata = '0;
   logic [DATA_BITS-1:0] prdata;
   logic pready;
   int   fail_count, pending_count;
   int   cycle_count = 0;
   logic [31:0] cur_low = 0;
   logic [15:0] cur_width = 10;
   logic [6:0]  cur_bins = 20;

   hbs_req_if req_chan ();
   hbs_rsp_if rsp_chan ();

   histogram_bin_statistics i_dut (
      .clock, .reset, .req_chan(req_chan.sink), .rsp_chan(rsp_chan.source),
      .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
   );

   hbs_checker i_checker (
      .clock, .reset, .req_mon(req_chan.sink), .rsp_mon(rsp_chan.sink),
      .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
      .fail_count, .pending_count
   );

   always #5 clock = ~clock;

   // cycle limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("histogram_bin_statistics_tb failed");
         $finish;
      end
   end

   // response side: random stall before each transfer, with quiet stretches
   initial begin
      int gap;
      rsp_chan.ready <= 1'b0;
      @(posedge clock iff !reset);
      forever begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
         if (gap != 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         @(posedge clock iff rsp_chan.valid);
      end
   end

   task automatic write_csr(logic [1:0] idx, logic [31:0] value);
      psel <= 1'b1;
      pwrite <= 1'b1;
      paddr <= ADDR_BITS'({idx, 2'b00});
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (idx)
         REG_RANGE_LOW:   cur_low = value;
         REG_BIN_WIDTH:   cur_width = value[15:0];
         REG_BINS_IN_USE: cur_bins = value[6:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic send_req(action_type act, logic [31:0] smp, logic [6:0] sel, bit pause);
      req_type rq;
      rq.action = act;
      rq.sample = smp;
      rq.bin_select = sel;
      if (pause) repeat ($urandom_range(0, 4)) @(posedge clock);
      req_chan.valid <= 1'b1;
      req_chan.payload <= rq;
      @(posedge clock iff req_chan.ready);
      req_chan.valid <= 1'b0;
      // the block is busy for at least the cycle after a transfer
      @(posedge clock);
   endtask

   task automatic wait_idle();
      @(posedge clock iff pending_count == 0);
      repeat (40) @(posedge clock);
   endtask

   // sample aimed near the configured range so all bins get hits
   function automatic logic [31:0] pick_sample();
      int unsigned k;
      logic [31:0] span;
      k = $urandom_range(0, 9);
      span = 32'(cur_width) * (cur_bins == 0 ? 1 : cur_bins);
      if (k == 0) return $urandom;
      if (k == 1) return cur_low - $urandom_range(0, 3);
      if (k == 2) return cur_low + span - $urandom_range(0, 2);
      return cur_low + ($urandom % (span + 1));
   endfunction

   task automatic random_phase(int count, int clear_odds);
      action_type act;
      int unsigned r;
      bit quiet;
      quiet = 1'b0;
      for (int i = 0; i < count; i++) begin
         if (i % 50 == 0) quiet = $urandom_range(0, 2) == 0;
         r = $urandom_range(0, 99);
         act = (r < 60) ? ACT_RECORD : (r < 85) ? ACT_READ :
               (r < 100 - clear_odds) ? ACT_TOTALS : ACT_CLEAR;
         send_req(act, pick_sample(), 7'($urandom_range(0, 127)), !quiet);
      end
   endtask

   initial begin
      req_chan.valid <= 1'b0;
      req_chan.payload <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: default setting, extremes and every action
      send_req(ACT_TOTALS, 0, 0, 0);
      send_req(ACT_READ, 0, 7'd5, 0);
      send_req(ACT_RECORD, 32'd0, 0, 0);
      send_req(ACT_RECORD, 32'd199, 0, 0);
      send_req(ACT_RECORD, 32'd200, 0, 0);
      send_req(ACT_RECORD, 32'hFFFF_FFFF, 0, 0);
      send_req(ACT_RECORD, 32'd15, 0, 0);
      send_req(ACT_READ, 0, 7'd0, 0);
      send_req(ACT_READ, 0, 7'd1, 0);
      send_req(ACT_READ, 0, 7'd21, 0);
      send_req(ACT_READ, 0, 7'd127, 0);
      send_req(ACT_TOTALS, 0, 0, 0);
      send_req(ACT_CLEAR, 0, 0, 0);
      send_req(ACT_READ, 0, 7'd21, 0);
      wait_idle();

      // zero width and zero bins, underflow and sum wrap
      write_csr(REG_RANGE_LOW, 32'h8000_0000);
      write_csr(REG_BIN_WIDTH, 32'd0);
      write_csr(REG_BINS_IN_USE, 32'd0);
      send_req(ACT_RECORD, 32'h7FFF_FFFF, 0, 0);
      send_req(ACT_RECORD, 32'h8000_0000, 0, 0);
      send_req(ACT_RECORD, 32'h8000_0001, 0, 0);
      send_req(ACT_RECORD, 32'hFFFF_FFFF, 0, 0);
      send_req(ACT_READ, 0, 7'd1, 0);
      send_req(ACT_READ, 0, 7'd2, 0);
      send_req(ACT_TOTALS, 0, 0, 0);
      wait_idle();

      // oversize bin count saturates, maximum width
      write_csr(REG_BINS_IN_USE, 32'd127);
      write_csr(REG_BIN_WIDTH, 32'hFFFF);
      write_csr(REG_RANGE_LOW, 32'd0);
      send_req(ACT_RECORD, 32'd65535 * 64 - 1, 0, 0);
      send_req(ACT_RECORD, 32'd65535 * 64, 0, 0);
      send_req(ACT_READ, 0, 7'd65, 0);
      send_req(ACT_READ, 0, 7'd64, 0);
      wait_idle();

      // random phases across several settings
      write_csr(REG_RANGE_LOW, 32'd1000);
      write_csr(REG_BIN_WIDTH, 32'd3);
      write_csr(REG_BINS_IN_USE, 32'd64);
      random_phase(300, 3);
      wait_idle();
      write_csr(REG_BINS_IN_USE, 32'd1);
      write_csr(REG_BIN_WIDTH, 32'd1);
      write_csr(REG_RANGE_LOW, 32'hFFFF_FFF0);
      random_phase(200, 3);
      wait_idle();
      write_csr(REG_RANGE_LOW, $urandom);
      write_csr(REG_BIN_WIDTH, $urandom_range(1, 65535));
      write_csr(REG_BINS_IN_USE, $urandom_range(1, 64));
      random_phase(250, 5);
      wait_idle();
      write_csr(REG_RANGE_LOW, 32'd0);
      write_csr(REG_BIN_WIDTH, 32'd7);
      write_csr(REG_BINS_IN_USE, 32'd10);
      random_phase(250, 2);

      // drain
      @(posedge clock iff pending_count == 0);
      repeat (50) @(posedge clock);
      if (fail_count == 0) begin
         $display("histogram_bin_statistics_tb passed");
      end else begin
         $display("histogram_bin_statistics_tb failed");
      end
      $finish;
   end

endmodule
